>>> rtl/core/cdq_pkg.sv
// cdq_pkg: command and status codes, request and response structs and cell
// control types for the circular deque with search
// no dependencies
`timescale 1ns / 1ps

package cdq_pkg;

    localparam int DEPTH_DEFAULT = 256;

    localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
    localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [2:0] CMD_POP_BACK   = 3'd3;
    localparam logic [2:0] CMD_SEARCH     = 3'd4;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EMPTY     = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic [2:0]         command;
        logic signed [31:0] value;
    } cdq_req_t;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic [8:0]         position;
        logic [1:0]         status;
        logic               is_empty;
        logic [8:0]         occupancy;
    } cdq_rsp_t;

    typedef enum logic [2:0] {
        CELL_HOLD = 3'd0,
        CELL_SHR  = 3'd1,
        CELL_SHL  = 3'd2,
        CELL_ROT  = 3'd3,
        CELL_LOAD = 3'd4
    } cdq_cell_op_t;

    typedef struct packed {
        cdq_cell_op_t op;
        logic [31:0]  value;
    } cdq_cell_ctrl_t;

endpackage

>>> rtl/core/cdq_cell.sv
// cdq_cell: one entry of the deque chain, shifts with its neighbors,
// takes part in the region rotation and loads at the back slot
// depends on cdq_pkg
`timescale 1ns / 1ps

module cdq_cell
    import cdq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT,
    parameter int IDX   = 0,
    localparam int CW   = $clog2(DEPTH + 1)
) (
    input  logic           aclk,
    input  cdq_cell_ctrl_t ctrl,
    input  logic [CW-1:0]  cnt,
    input  logic [CW-1:0]  last,
    input  logic [31:0]    left_data,
    input  logic [31:0]    right_data,
    input  logic [31:0]    wrap_data,
    output logic [31:0]    data_out
);

    logic [31:0] data_reg;
    logic [31:0] data_next;
    logic        is_last;
    logic        is_tail;

    assign is_last = (last == CW'(IDX));
    assign is_tail = (cnt == CW'(IDX));

    always_comb begin
        data_next = data_reg;
        unique case (ctrl.op)
            CELL_HOLD: data_next = data_reg;
            CELL_SHR:  data_next = left_data;
            CELL_SHL:  data_next = right_data;
            CELL_ROT:  data_next = is_last ? wrap_data : right_data;
            CELL_LOAD: data_next = is_tail ? ctrl.value : data_reg;
            default:   data_next = data_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data_out = data_reg;

endmodule

>>> rtl/core/circular_deque_with_search_unit.sv
// circular_deque_with_search_unit: deque of signed 32-bit values in a chain of cells
// pushes, unused codes and empty pops finish in the execute state; a pop shifts the front
// entry out in a finish state, pop back after rotating the live region if it holds more
// than one entry; search on a non-empty deque rotates the live region once (cell rotation);
// one request at a time, a waiting result does not block acceptance; reset: synchronous
// active-low, clears control and occupancy, no clearing pass; entries undefined until pushed
`timescale 1ns / 1ps

module circular_deque_with_search_unit
    import cdq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  cdq_req_t s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output cdq_rsp_t m_data
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = (CW > 9) ? CW : 9;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_EXEC = 5'b00010,
        S_ROT  = 5'b00100,
        S_FIN  = 5'b01000,
        S_DONE = 5'b10000
    } state_t;

    state_t         state_reg, state_next;
    logic [CW-1:0]  count_reg, count_next;
    logic [2:0]     cmd_reg, cmd_next;
    logic [31:0]    val_reg, val_next;
    logic [CW-1:0]  step_reg, step_next;
    logic [CW-1:0]  end_reg, end_next;
    logic [CW-1:0]  pos_reg, pos_next;
    logic [31:0]    res_reg, res_next;
    logic [1:0]     status_reg, status_next;
    logic           m_valid_reg, m_valid_next;
    cdq_rsp_t       m_data_reg, m_data_next;

    cdq_cell_ctrl_t cell_ctrl;
    logic [CW-1:0]  last_idx;
    logic [31:0]    cell_data [DEPTH];
    logic [31:0]    head;
    logic [PW-1:0]  pos_ext;
    logic [PW-1:0]  cnt_ext;

    assign head     = cell_data[0];
    assign last_idx = count_reg - CW'(1);
    assign pos_ext  = PW'(pos_reg);
    assign cnt_ext  = PW'(count_reg);

    // row of cells, front entry in cell 0 between requests
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [31:0] left_d;
        logic [31:0] right_d;
        if (g == 0) begin : g_first
            assign left_d = cell_ctrl.value;
        end else begin : g_mid_l
            assign left_d = cell_data[g-1];
        end
        if (g == DEPTH - 1) begin : g_lastc
            assign right_d = cell_data[0];
        end else begin : g_mid_r
            assign right_d = cell_data[g+1];
        end
        cdq_cell #(
            .DEPTH (DEPTH),
            .IDX   (g)
        ) u_cell (
            .aclk       (aclk),
            .ctrl       (cell_ctrl),
            .cnt        (count_reg),
            .last       (last_idx),
            .left_data  (left_d),
            .right_data (right_d),
            .wrap_data  (cell_data[0]),
            .data_out   (cell_data[g])
        );
    end

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        cmd_next       = cmd_reg;
        val_next       = val_reg;
        step_next      = step_reg;
        end_next       = end_reg;
        pos_next       = pos_reg;
        res_next       = res_reg;
        status_next    = status_reg;
        m_valid_next   = m_valid_reg;
        m_data_next    = m_data_reg;
        cell_ctrl.op    = CELL_HOLD;
        cell_ctrl.value = val_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd_next    = s_data.command;
                    val_next    = s_data.value;
                    pos_next    = '0;
                    res_next    = '0;
                    status_next = ST_OK;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC: begin
                state_next = S_DONE;
                case (cmd_reg)
                    CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                        if (count_reg == CW'(DEPTH)) begin
                            status_next = ST_FULL;
                        end else begin
                            cell_ctrl.op = (cmd_reg == CMD_PUSH_FRONT) ? CELL_SHR : CELL_LOAD;
                            count_next   = count_reg + CW'(1);
                        end
                    end
                    CMD_POP_FRONT: begin
                        if (count_reg == '0) begin
                            status_next = ST_EMPTY;
                        end else begin
                            state_next = S_FIN;
                        end
                    end
                    CMD_POP_BACK: begin
                        if (count_reg == '0) begin
                            status_next = ST_EMPTY;
                        end else if (count_reg == CW'(1)) begin
                            state_next = S_FIN;
                        end else begin
                            step_next  = '0;
                            end_next   = count_reg - CW'(2);
                            state_next = S_ROT;
                        end
                    end
                    CMD_SEARCH: begin
                        status_next = ST_NOT_FOUND;
                        if (count_reg != '0) begin
                            step_next  = '0;
                            end_next   = last_idx;
                            state_next = S_ROT;
                        end
                    end
                    default: begin
                        status_next = ST_OK;
                    end
                endcase
            end
            S_ROT: begin
                // rotate the live region by one, front goes to the back
                cell_ctrl.op = CELL_ROT;
                if (cmd_reg == CMD_SEARCH && status_reg == ST_NOT_FOUND && head == val_reg) begin
                    pos_next    = step_reg + CW'(1);
                    status_next = ST_OK;
                end
                step_next = step_reg + CW'(1);
                if (step_reg == end_reg) begin
                    state_next = (cmd_reg == CMD_SEARCH) ? S_DONE : S_FIN;
                end
            end
            S_FIN: begin
                cell_ctrl.op = CELL_SHL;
                res_next     = head;
                count_next   = count_reg - CW'(1);
                state_next   = S_DONE;
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next             = 1'b1;
                    m_data_next.result_value = res_reg;
                    m_data_next.position     = pos_ext[8:0];
                    m_data_next.status       = status_reg;
                    m_data_next.is_empty     = (count_reg == '0);
                    m_data_next.occupancy    = cnt_ext[8:0];
                    state_next               = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg    <= cmd_next;
        val_reg    <= val_next;
        step_reg   <= step_next;
        end_reg    <= end_next;
        pos_reg    <= pos_next;
        res_reg    <= res_next;
        status_reg <= status_next;
        m_data_reg <= m_data_next;
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("occupancy above depth");

    a_rot_count_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_ROT |=> $stable(count_reg))
        else $error("occupancy changed during rotation");

    a_rot_step_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_ROT |-> step_reg <= end_reg)
        else $error("rotation step past its end");

    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result raised outside the completion state");

    a_empty_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_data_reg.status == ST_EMPTY |-> m_data_reg.is_empty)
        else $error("pop on empty reported with entries held");

endmodule

>>> verif/circular_deque_with_search_unit_tb.sv
// circular_deque_with_search_unit_tb: self-checking bench for the circular deque with search,
// random push, pop and search traffic with idle gaps on both channels, checked in order
// depends on cdq_pkg and circular_deque_with_search_unit
`timescale 1ns / 1ps

module circular_deque_with_search_unit_tb;
    import cdq_pkg::*;

    localparam int QDEPTH = DEPTH_DEFAULT;
    localparam int DRAIN_CYCLES = QDEPTH + 48;

    localparam logic [2:0] CMD_RESERVED_A = 3'd5;
    localparam logic [2:0] CMD_RESERVED_B = 3'd6;
    localparam logic [2:0] CMD_RESERVED_C = 3'd7;

    typedef struct packed {
        logic     hold;
        cdq_req_t req;
    } pend_item_t;

    typedef enum logic [1:0] {
        PH_MIX,
        PH_FILL,
        PH_DRAIN
    } traffic_phase_t;

    logic     aclk = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    cdq_req_t s_data = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    cdq_rsp_t m_data;

    pend_item_t        pend_q[$];
    cdq_rsp_t          deque_exp_q[$];
    logic signed [31:0] steer_q[$];

    // shadow deque state
    logic signed [31:0] shadow_mem [0:QDEPTH-1];
    logic [7:0]         shadow_front = '0;
    logic [8:0]         shadow_count = '0;

    int err_cnt = 0;
    int req_cnt = 0;
    int rsp_cnt = 0;
    int n_push = 0;
    int n_pop = 0;
    int n_search = 0;
    int n_reserved = 0;
    int n_full = 0;
    int n_empty = 0;
    int n_hit = 0;
    int n_miss = 0;
    int peak_occ = 0;

    circular_deque_with_search_unit u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic cdq_rsp_t apply_deque_cmd(input cdq_req_t req);
        cdq_rsp_t   rsp;
        logic [7:0] slot;
        logic       hit;
        int         i;
        rsp = '0;
        hit = 1'b0;
        case (req.command)
            CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                n_push++;
                if (shadow_count == 9'(QDEPTH)) begin
                    rsp.status = ST_FULL;
                    n_full++;
                end else if (req.command == CMD_PUSH_FRONT) begin
                    shadow_front = shadow_front - 8'd1;
                    shadow_mem[shadow_front] = req.value;
                    shadow_count = shadow_count + 9'd1;
                end else begin
                    slot = shadow_front + shadow_count[7:0];
                    shadow_mem[slot] = req.value;
                    shadow_count = shadow_count + 9'd1;
                end
            end
            CMD_POP_FRONT, CMD_POP_BACK: begin
                n_pop++;
                if (shadow_count == 9'd0) begin
                    rsp.status = ST_EMPTY;
                    n_empty++;
                end else if (req.command == CMD_POP_FRONT) begin
                    rsp.result_value = shadow_mem[shadow_front];
                    shadow_front = shadow_front + 8'd1;
                    shadow_count = shadow_count - 9'd1;
                end else begin
                    slot = shadow_front + 8'(shadow_count - 9'd1);
                    rsp.result_value = shadow_mem[slot];
                    shadow_count = shadow_count - 9'd1;
                end
            end
            CMD_SEARCH: begin
                n_search++;
                rsp.status = ST_NOT_FOUND;
                for (i = 0; i < int'(shadow_count) && !hit; i++) begin
                    slot = shadow_front + 8'(i);
                    if (shadow_mem[slot] == req.value) begin
                        hit = 1'b1;
                        rsp.position = 9'(i + 1);
                        rsp.status = ST_OK;
                    end
                end
                if (hit) n_hit++;
                else n_miss++;
            end
            default: begin
                n_reserved++;
            end
        endcase
        rsp.is_empty = (shadow_count == 9'd0);
        rsp.occupancy = shadow_count;
        if (int'(shadow_count) > peak_occ) peak_occ = int'(shadow_count);
        return rsp;
    endfunction

    task automatic check_rsp(input cdq_rsp_t exp_r, input cdq_rsp_t got);
        if (got.result_value !== exp_r.result_value) begin
            $error("result_value: expected %0d, got %0d", exp_r.result_value, got.result_value);
            err_cnt++;
        end
        if (got.position !== exp_r.position) begin
            $error("position: expected %0d, got %0d", exp_r.position, got.position);
            err_cnt++;
        end
        if (got.status !== exp_r.status) begin
            $error("status: expected %0d, got %0d", exp_r.status, got.status);
            err_cnt++;
        end
        if (got.is_empty !== exp_r.is_empty) begin
            $error("is_empty: expected %0d, got %0d", exp_r.is_empty, got.is_empty);
            err_cnt++;
        end
        if (got.occupancy !== exp_r.occupancy) begin
            $error("occupancy: expected %0d, got %0d", exp_r.occupancy, got.occupancy);
            err_cnt++;
        end
    endtask

    // queue a request and track contents so searches can aim at live values
    task automatic queue_request(input logic [2:0] cmd, input logic signed [31:0] val,
                                 input logic hold);
        pend_item_t item;
        item.hold = hold;
        item.req.command = cmd;
        item.req.value = val;
        pend_q.push_back(item);
        case (cmd)
            CMD_PUSH_FRONT: if (steer_q.size() < QDEPTH) steer_q.push_front(val);
            CMD_PUSH_BACK: if (steer_q.size() < QDEPTH) steer_q.push_back(val);
            CMD_POP_FRONT: if (steer_q.size() > 0) void'(steer_q.pop_front());
            CMD_POP_BACK: if (steer_q.size() > 0) void'(steer_q.pop_back());
            default: ;
        endcase
    endtask

    function automatic logic signed [31:0] pick_value();
        logic signed [31:0] v;
        int r;
        r = $urandom_range(99);
        if (r < 25) begin
            v = $urandom_range(6);
            v = v - 32'sd3;
        end else if (r < 35) begin
            case ($urandom_range(3))
                0: v = 32'h8000_0000;
                1: v = 32'h7fff_ffff;
                2: v = 32'h0000_0000;
                default: v = 32'hffff_ffff;
            endcase
        end else begin
            v = $urandom;
        end
        return v;
    endfunction

    // request driver
    always @(posedge aclk) begin : req_driver
        logic idle;
        logic calm;
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_data <= '0;
        end else begin
            if (s_valid && s_ready) begin
                deque_exp_q.push_back(apply_deque_cmd(s_data));
                req_cnt++;
            end
            calm = (req_cnt >= 200 && req_cnt < 360);
            idle = !calm && ($urandom_range(99) < 32);
            if (!s_valid || s_ready) begin
                if (pend_q.size() != 0 && !idle
                        && !(pend_q[0].hold && deque_exp_q.size() != 0)) begin
                    s_valid <= 1'b1;
                    s_data <= pend_q[0].req;
                    void'(pend_q.pop_front());
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // response monitor
    always @(posedge aclk) begin : rsp_monitor
        logic idle;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (deque_exp_q.size() == 0) begin
                    $error("response with no request outstanding");
                    err_cnt++;
                end else begin
                    check_rsp(deque_exp_q.pop_front(), m_data);
                end
                rsp_cnt++;
            end
            idle = !(rsp_cnt >= 200 && rsp_cnt < 360) && ($urandom_range(99) < 32);
            m_ready <= !idle;
        end
    end

    initial begin
        #10_000_000;
        $display("** circular_deque_with_search_unit: FAILED **");
        $finish;
    end

    initial begin : stimulus
        traffic_phase_t     phase;
        logic [2:0]         cmd;
        logic signed [31:0] val;
        int n;
        int r;
        int phase_len;
        int edge_hits;
        int push_pct;
        int pop_pct;
        logic hold;

        // directed: empty cases, extremes, duplicates, reserved codes
        queue_request(CMD_POP_FRONT, 32'h1234_5678, 1'b0);
        queue_request(CMD_POP_BACK, 32'hffff_ffff, 1'b0);
        queue_request(CMD_SEARCH, 32'h0000_0000, 1'b0);
        queue_request(CMD_PUSH_BACK, 32'h7fff_ffff, 1'b0);
        queue_request(CMD_PUSH_FRONT, 32'h8000_0000, 1'b0);
        queue_request(CMD_PUSH_BACK, 32'hffff_ffff, 1'b0);
        queue_request(CMD_PUSH_FRONT, 32'h0000_0000, 1'b0);
        queue_request(CMD_PUSH_BACK, 32'h8000_0000, 1'b0);
        queue_request(CMD_SEARCH, 32'h8000_0000, 1'b0);
        queue_request(CMD_SEARCH, 32'hffff_ffff, 1'b0);
        queue_request(CMD_SEARCH, 32'h8000_0000, 1'b0);
        queue_request(CMD_SEARCH, 32'h0000_3039, 1'b0);
        queue_request(CMD_RESERVED_A, 32'hffff_ffff, 1'b0);
        queue_request(CMD_RESERVED_B, 32'haaaa_aaaa, 1'b0);
        queue_request(CMD_RESERVED_C, 32'h5555_5555, 1'b0);
        queue_request(CMD_POP_BACK, 32'h0000_0000, 1'b0);
        queue_request(CMD_POP_FRONT, 32'h0000_0000, 1'b0);
        queue_request(CMD_POP_BACK, 32'h0000_0000, 1'b0);
        queue_request(CMD_POP_FRONT, 32'h0000_0000, 1'b0);
        queue_request(CMD_POP_FRONT, 32'h0000_0000, 1'b0);
        queue_request(CMD_POP_BACK, 32'h0000_0000, 1'b0);
        queue_request(CMD_PUSH_FRONT, 32'h5555_5555, 1'b0);
        queue_request(CMD_POP_BACK, 32'haaaa_aaaa, 1'b0);

        // random: mixed traffic, then fill to full, then drain to empty
        phase = PH_MIX;
        phase_len = 0;
        edge_hits = 0;
        for (n = 0; n < 780; n++) begin
            r = $urandom_range(99);
            hold = (n % 250 == 0);
            case (phase)
                PH_FILL: begin
                    push_pct = 80;
                    pop_pct = 8;
                end
                PH_DRAIN: begin
                    push_pct = 8;
                    pop_pct = 80;
                end
                default: begin
                    push_pct = 40;
                    pop_pct = 30;
                end
            endcase
            if (r < 3) begin
                cmd = 3'(CMD_RESERVED_A + 3'($urandom_range(2)));
            end else begin
                r = $urandom_range(99);
                if (r < push_pct) begin
                    cmd = $urandom_range(1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
                end else if (r < push_pct + pop_pct) begin
                    cmd = $urandom_range(1) ? CMD_POP_FRONT : CMD_POP_BACK;
                end else begin
                    cmd = CMD_SEARCH;
                end
            end
            if (cmd == CMD_SEARCH && steer_q.size() > 0 && $urandom_range(99) < 70) begin
                val = steer_q[$urandom_range(steer_q.size() - 1)];
            end else begin
                val = pick_value();
            end
            queue_request(cmd, val, hold);
            phase_len++;
            case (phase)
                PH_MIX: begin
                    if (phase_len >= 60) begin
                        phase = PH_FILL;
                        phase_len = 0;
                        edge_hits = 0;
                    end
                end
                PH_FILL: begin
                    if (steer_q.size() == QDEPTH) edge_hits++;
                    if (edge_hits >= 8) begin
                        phase = PH_DRAIN;
                        phase_len = 0;
                        edge_hits = 0;
                    end
                end
                default: begin
                    if (steer_q.size() == 0) edge_hits++;
                    if (edge_hits >= 6) begin
                        phase = PH_MIX;
                        phase_len = 0;
                        edge_hits = 0;
                    end
                end
            endcase
        end

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        while (pend_q.size() != 0 || s_valid || deque_exp_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("ran %0d requests: %0d push, %0d pop, %0d search, %0d reserved code",
                 req_cnt, n_push, n_pop, n_search, n_reserved);
        $display("push on full %0d, pop on empty %0d, search hit %0d miss %0d, peak occupancy %0d",
                 n_full, n_empty, n_hit, n_miss, peak_occ);
        if (err_cnt == 0 && deque_exp_q.size() == 0) begin
            $display("** circular_deque_with_search_unit: PASSED **");
        end else begin
            $display("** circular_deque_with_search_unit: FAILED **");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/cdq_pkg.sv
rtl/core/cdq_cell.sv
rtl/core/circular_deque_with_search_unit.sv
verif/circular_deque_with_search_unit_tb.sv
